@@ rtl/hlpd_pkg.sv @@
// hlpd_pkg: shared types, constants and the hex digit decoder
// for the hex length prefix deframer and its checker
// no dependencies
package hlpd_pkg;

  localparam int unsigned HEADER_DIGITS = 6;
  localparam int unsigned LEN_W         = 24;
  localparam int unsigned CNT_W         = $clog2(HEADER_DIGITS + 1);
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DIGIT = 2'd1,
    STATUS_TRUNC     = 2'd2
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    logic [7:0] t;
    r.ok  = 1'b0;
    r.val = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t     = c - CH_0;
      r.ok  = 1'b1;
      r.val = t[3:0];
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      t     = c - CH_LC_A;
      r.ok  = 1'b1;
      r.val = t[3:0] + HEX_TEN;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      t     = c - CH_UC_A;
      r.ok  = 1'b1;
      r.val = t[3:0] + HEX_TEN;
    end
    return r;
  endfunction

endpackage

@@ rtl/hex_length_prefix_deframer.sv @@
// hex_length_prefix_deframer: strips six-digit hex length headers from a byte stream
// and passes the payload bytes with length, end mark and status
// depends on hlpd_pkg
//
//   channel | handshake            | fields
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid_i/in_stall_o | data_byte_i, end_of_data_i
//   out     | out_valid_o/out_stall_i | payload_byte_o, payload_valid_o, frame_end_o,
//           |                      | frame_length_o, status_o
//
// one item per cycle while not stalled; results are held in the single result register
// header digits cause no result unless they end or break the frame
// reset clears the phase, counters and result valid; no clearing pass
// a held result stalls the input only while out_stall_i is high
module hex_length_prefix_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            end_of_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      payload_byte_o,
  output logic                            payload_valid_o,
  output logic                            frame_end_o,
  output logic [hlpd_pkg::LEN_W-1:0]      frame_length_o,
  output logic [hlpd_pkg::STATUS_W-1:0]   status_o
);
  import hlpd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   rem_q, rem_d;

  logic               out_valid_q;
  logic [7:0]         byte_q;
  logic               pv_q;
  logic               end_q;
  logic [LEN_W-1:0]   len_q;
  status_e            status_q;

  logic               res_valid;
  logic [7:0]         res_byte;
  logic               res_pv;
  logic               res_end;
  logic [LEN_W-1:0]   res_len;
  status_e            res_status;

  logic               in_acc;
  hex_digit_t         hex;
  logic [LEN_W-1:0]   acc_shift;
  logic [LEN_W-1:0]   rem_dec;
  logic               last_digit;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign hex        = hex_decode(data_byte_i);
  assign acc_shift  = {acc_q[LEN_W-5:0], hex.val};
  assign rem_dec    = rem_q - LEN_W'(1);
  assign last_digit = (cnt_q == CNT_W'(HEADER_DIGITS - 1));

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    case (phase_q)
      PH_DISCARD: begin
        if (end_of_data_i) begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
          acc_d   = '0;
          rem_d   = '0;
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (rem_dec == '0 || end_of_data_i) begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
          acc_d   = '0;
          rem_d   = '0;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        if (!hex.ok) begin
          if (end_of_data_i) begin
            cnt_d = '0;
            acc_d = '0;
            rem_d = '0;
          end else begin
            phase_d = PH_DISCARD;
          end
        end else begin
          acc_d = acc_shift;
          cnt_d = cnt_q + CNT_W'(1);
          if (last_digit) begin
            if (acc_shift == '0 || end_of_data_i) begin
              cnt_d = '0;
              acc_d = '0;
              rem_d = '0;
            end else begin
              phase_d = PH_PAYLOAD;
              cnt_d   = '0;
              rem_d   = acc_shift;
            end
          end else if (end_of_data_i) begin
            cnt_d = '0;
            acc_d = '0;
            rem_d = '0;
          end
        end
      end
    endcase
  end

  // result for this item
  always_comb begin
    res_valid  = 1'b0;
    res_byte   = '0;
    res_pv     = 1'b0;
    res_end    = 1'b0;
    res_len    = '0;
    res_status = STATUS_OK;
    case (phase_q)
      PH_DISCARD: begin
        res_valid = 1'b0;
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_byte  = data_byte_i;
        res_pv    = 1'b1;
        res_end   = (rem_dec == '0);
        res_len   = acc_q;
        if (rem_dec != '0 && end_of_data_i) begin
          res_status = STATUS_TRUNC;
        end
      end
      default: begin
        if (!hex.ok) begin
          res_valid  = 1'b1;
          res_len    = acc_q;
          res_status = STATUS_BAD_DIGIT;
        end else if (last_digit && acc_shift == '0) begin
          res_valid = 1'b1;
          res_end   = 1'b1;
        end else if (end_of_data_i) begin
          res_valid  = 1'b1;
          res_len    = acc_shift;
          res_status = STATUS_TRUNC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_acc & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      byte_q   <= res_byte;
      pv_q     <= res_pv;
      end_q    <= res_end;
      len_q    <= res_len;
      status_q <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = byte_q;
  assign payload_valid_o = pv_q;
  assign frame_end_o     = end_q;
  assign frame_length_o  = len_q;
  assign status_o        = status_q;

endmodule

@@ rtl/hlpd_checker.sv @@
// hlpd_checker: port-level assertions for the hex length prefix deframer
// bound to hex_length_prefix_deframer; depends on hlpd_pkg
module hlpd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [7:0]                      payload_byte_o,
  input logic                            payload_valid_o,
  input logic                            frame_end_o,
  input logic [hlpd_pkg::LEN_W-1:0]      frame_length_o,
  input logic [hlpd_pkg::STATUS_W-1:0]   status_o
);
  import hlpd_pkg::*;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(frame_length_o) && $stable(status_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  a_end_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> status_o == STATUS_OK && !$isunknown(frame_length_o))
    else $error("frame end with error status");

  a_empty_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'd0)
    else $error("non-payload result carries a byte");

  a_bad_digit_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_BAD_DIGIT |-> !payload_valid_o && !frame_end_o)
    else $error("header error carries payload");

endmodule

bind hex_length_prefix_deframer hlpd_checker u_hlpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .payload_byte_o  (payload_byte_o),
  .payload_valid_o (payload_valid_o),
  .frame_end_o     (frame_end_o),
  .frame_length_o  (frame_length_o),
  .status_o        (status_o)
);

@@ bench/hex_length_prefix_deframer_tb.sv @@
// hex_length_prefix_deframer_tb: self-checking bench for the hex length prefix deframer
// a queue-fed driver, a predictor of the deframing and a monitor that compares each result
// depends on hlpd_pkg and hex_length_prefix_deframer
module hex_length_prefix_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlpd_pkg::*;

  localparam int unsigned ITEMS    = 1700;
  localparam int unsigned LIMIT_NS = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       hold;
  } stream_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             valid;
    logic             last;
    logic [LEN_W-1:0] len;
    status_e          status;
  } deframed_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'h00;
  logic                end_of_data = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          payload_byte;
  logic                payload_valid;
  logic                frame_end;
  logic [LEN_W-1:0]    frame_length;
  logic [STATUS_W-1:0] status;

  stream_t   stream_q[$];
  deframed_t deframed_q[$];
  stream_t   nxt;
  deframed_t got;
  deframed_t want;
  int        mismatches = 0;
  int        cyc = 0;
  logic      calm;
  logic      hold_next = 1'b0;

  // predictor state
  phase_e           ph;
  logic [CNT_W-1:0] digits;
  logic [LEN_W-1:0] acc;
  logic [LEN_W-1:0] left;

  hex_length_prefix_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_data_i  (end_of_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .payload_byte_o (payload_byte),
    .payload_valid_o(payload_valid),
    .frame_end_o    (frame_end),
    .frame_length_o (frame_length),
    .status_o       (status)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  assign calm = (cyc >= 1000) && (cyc < 1700);

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c;
    if (c >= "A" && c <= "Z") begin
      lc = c + 8'd32;
    end
    if (lc >= "0" && lc <= "9") begin
      return {1'b1, 4'(lc - "0")};
    end
    if (lc >= "a" && lc <= "f") begin
      return {1'b1, 4'(lc - "a" + 8'd10)};
    end
    return 5'b0;
  endfunction

  task automatic restart();
    ph     = PH_HEADER;
    digits = '0;
    acc    = '0;
    left   = '0;
  endtask

  task automatic deframe(input logic [7:0] b, input logic eod);
    deframed_t  r;
    logic       hit;
    logic [4:0] d;
    r   = '0;
    hit = 1'b0;
    case (ph)
      PH_DISCARD: begin
        if (eod) begin
          restart();
        end
      end
      PH_PAYLOAD: begin
        left    = left - 1'b1;
        r.data  = b;
        r.valid = 1'b1;
        r.len   = acc;
        hit     = 1'b1;
        if (left == '0) begin
          r.last = 1'b1;
          restart();
        end else if (eod) begin
          r.status = STATUS_TRUNC;
          restart();
        end
      end
      default: begin
        ph = PH_HEADER;
        d  = nibble_of(b);
        if (!d[4]) begin
          r.len    = acc;
          r.status = STATUS_BAD_DIGIT;
          hit      = 1'b1;
          if (eod) begin
            restart();
          end else begin
            ph = PH_DISCARD;
          end
        end else begin
          acc    = {acc[LEN_W-5:0], d[3:0]};
          digits = digits + 1'b1;
          if (digits >= HEADER_DIGITS) begin
            if (acc == '0) begin
              r.last = 1'b1;
              hit    = 1'b1;
              restart();
            end else if (eod) begin
              r.len    = acc;
              r.status = STATUS_TRUNC;
              hit      = 1'b1;
              restart();
            end else begin
              ph     = PH_PAYLOAD;
              digits = '0;
              left   = acc;
            end
          end else if (eod) begin
            r.len    = acc;
            r.status = STATUS_TRUNC;
            hit      = 1'b1;
            restart();
          end
        end
      end
    endcase
    if (hit) begin
      deframed_q.push_back(r);
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  task automatic check_field(input string name, input logic [LEN_W-1:0] act,
                             input logic [LEN_W-1:0] exp_v);
    if (act !== exp_v) begin
      report($sformatf("%s expected %0h got %0h", name, exp_v, act));
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      restart();
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe(data_byte, end_of_data);
      end
      if (!in_valid || !in_stall) begin
        if (stream_q.size() != 0 && !(stream_q[0].hold && deframed_q.size() != 0) &&
            (calm || $urandom_range(99) >= 6)) begin
          nxt = stream_q.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= nxt.data;
          end_of_data <= nxt.eod;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          report($sformatf("unexpected result byte %0h len %0h status %0d",
                           payload_byte, frame_length, status));
        end else begin
          want = deframed_q.pop_front();
          check_field("payload_byte", LEN_W'(payload_byte), LEN_W'(want.data));
          check_field("payload_valid", LEN_W'(payload_valid), LEN_W'(want.valid));
          check_field("frame_end", LEN_W'(frame_end), LEN_W'(want.last));
          check_field("frame_length", frame_length, want.len);
          check_field("status", LEN_W'(status), LEN_W'(want.status));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 6);
    end
  end

  task automatic put(input logic [7:0] b, input logic eod);
    stream_q.push_back('{data: b, eod: eod, hold: hold_next});
    hold_next = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return "0" + n;
    end
    return ($urandom_range(1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    logic [4:0] d;
    c = 8'($urandom_range(255));
    d = nibble_of(c);
    while (d[4]) begin
      c = 8'($urandom_range(255));
      d = nibble_of(c);
    end
    return c;
  endfunction

  task automatic put_header(input logic [LEN_W-1:0] len, input logic eod_last);
    for (int i = HEADER_DIGITS - 1; i >= 0; i--) begin
      put(hex_char(len[i*4 +: 4]), eod_last && (i == 0));
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned frames;
    logic [LEN_W-1:0] len;

    // directed part
    put_header('0, 1'b0);
    put_header(24'd2, 1'b0);
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put_header(24'hFFFFFF, 1'b1);
    put("G", 1'b1);
    put("7", 1'b0);
    put(":", 1'b0);
    put(8'h41, 1'b0);
    put(8'h80, 1'b1);
    put("0", 1'b0);
    put("0", 1'b1);
    put_header(24'd3, 1'b0);
    put(8'h5A, 1'b1);

    frames    = 0;
    hold_next = 1'b1;
    while (stream_q.size() < ITEMS) begin
      frames++;
      if (frames == 60 || frames == 250) begin
        hold_next = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 68) begin
        len = LEN_W'($urandom_range(0, 12));
        put_header(len, 1'b0);
        for (int k = 0; k < len; k++) begin
          put(8'($urandom_range(255)), (k == len - 1) && $urandom_range(1));
        end
      end else if (pick < 77) begin
        len = LEN_W'($urandom) | 24'h10;
        put_header(len, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) put(8'($urandom_range(255)), 1'b0);
        put(8'($urandom_range(255)), 1'b1);
      end else if (pick < 84) begin
        n = $urandom_range(1, HEADER_DIGITS);
        for (int k = 0; k < n; k++) begin
          put(hex_char(4'($urandom_range(15))), k == n - 1);
        end
      end else if (pick < 93) begin
        n = $urandom_range(0, HEADER_DIGITS - 1);
        repeat (n) put(hex_char(4'($urandom_range(15))), 1'b0);
        if ($urandom_range(3) == 0) begin
          put(junk_char(), 1'b1);
        end else begin
          put(junk_char(), 1'b0);
          n = $urandom_range(0, 5);
          repeat (n) put(8'($urandom_range(255)), 1'b0);
          put(8'($urandom_range(255)), 1'b1);
        end
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) put(8'($urandom_range(255)), $urandom_range(7) == 0);
        put(8'($urandom_range(255)), 1'b1);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() != 0 || in_valid) @(posedge clk_i);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS * 1ns);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
